>>> rtl/bal_pkg.sv
`timescale 1ns / 1ps

package bal_pkg;

  // instruction class carried in tuser
  typedef enum logic {
    OP_BRANCH = 1'b0,
    OP_LOOP   = 1'b1
  } op_e;

  // condition codes from opcode bits 11..8
  typedef enum logic [3:0] {
    CC_T  = 4'd0,
    CC_F  = 4'd1,
    CC_HI = 4'd2,
    CC_LS = 4'd3,
    CC_CC = 4'd4,
    CC_CS = 4'd5,
    CC_NE = 4'd6,
    CC_EQ = 4'd7,
    CC_VC = 4'd8,
    CC_VS = 4'd9,
    CC_PL = 4'd10,
    CC_MI = 4'd11,
    CC_GE = 4'd12,
    CC_LT = 4'd13,
    CC_GT = 4'd14,
    CC_LE = 4'd15
  } cond_e;

  // cycle charges
  localparam logic [3:0] CYC_SHORT_NT = 4'd8;
  localparam logic [3:0] CYC_TAKEN    = 4'd10;
  localparam logic [3:0] CYC_WORD_NT  = 4'd12;
  localparam logic [3:0] CYC_EXPIRED  = 4'd14;

  // counter value that ends a loop
  localparam logic [15:0] COUNT_EXPIRED = 16'hFFFF;

  // condition test, flags packed n z v c from bit 3 down
  function automatic logic cond_true(cond_e cc, logic [3:0] nzvc);
    logic n;
    logic z;
    logic v;
    logic c;
    logic res;
    n = nzvc[3];
    z = nzvc[2];
    v = nzvc[1];
    c = nzvc[0];
    unique case (cc)
      CC_T:  res = 1'b1;
      CC_F:  res = 1'b0;
      CC_HI: res = !c && !z;
      CC_LS: res = c || z;
      CC_CC: res = !c;
      CC_CS: res = c;
      CC_NE: res = !z;
      CC_EQ: res = z;
      CC_VC: res = !v;
      CC_VS: res = v;
      CC_PL: res = !n;
      CC_MI: res = n;
      CC_GE: res = (n == v);
      CC_LT: res = (n != v);
      CC_GT: res = !z && (n == v);
      CC_LE: res = z || (n != v);
    endcase
    return res;
  endfunction

endpackage

>>> rtl/branch_and_loop_unit.sv
`timescale 1ns / 1ps

// branch and loop resolution unit
// slave stream: one instruction per word; tuser selects a conditional or
//   always branch (0) or a decrement-and-branch loop (1); tdata carries the
//   opcode word, extension word, instruction address, flags and loop count
// master stream: one result word per instruction with next pc, taken flag,
//   decremented count and its write enable, extension-used flag and the
//   cycle charge
// timing: the input register loads on the accepting edge; the result register
//   loads from it after the condition test and the 32-bit target add, and
//   m_axis_tvalid rises with it
// throughput: one instruction per cycle while m_axis_tready stays high, set by
//   the combinational condition/target logic between the two registers
// reset: both stages are emptied, no result is presented
// stall: while m_axis_tready is low the result word holds; the input stage
//   still takes one more word, then s_axis_tready drops until the result
//   register frees up
module branch_and_loop_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] inst_word, [31:16] ext_word, [63:32] instr_addr,
  // [68:64] cond_flags, [84:69] count_in, [87:85] zero
  input  logic [87:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] next_pc, [32] taken, [48:33] count_out, [49] count_write,
  // [50] used_ext, [54:51] cycles, [55] zero
  output logic [55:0] m_axis_tdata
);

  // input stage
  logic          in_valid_q, in_valid_d;
  bal_pkg::op_e  op_q;
  logic [15:0]   iw_q;
  logic [15:0]   ew_q;
  logic [31:0]   addr_q;
  logic [4:0]    flags_q;
  logic [15:0]   cnt_q;

  // result stage
  logic          out_valid_q, out_valid_d;
  logic [55:0]   out_q, out_d;

  logic          out_load;
  logic          in_load;

  // stage advance
  assign out_load      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_load || (in_valid_q && !out_load);
  assign out_valid_d   = out_load ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      op_q    <= bal_pkg::op_e'(s_axis_tuser);
      iw_q    <= s_axis_tdata[15:0];
      ew_q    <= s_axis_tdata[31:16];
      addr_q  <= s_axis_tdata[63:32];
      flags_q <= s_axis_tdata[68:64];
      cnt_q   <= s_axis_tdata[84:69];
    end
  end

  // resolve the instruction
  bal_pkg::cond_e cc;
  logic [7:0]     sdisp;
  logic           short_zero;
  logic           cond_ok;
  logic [31:0]    disp;
  logic [31:0]    target;
  logic [15:0]    cnt_dec;
  logic [31:0]    next_pc;
  logic           taken;
  logic [15:0]    count_out;
  logic           count_write;
  logic           used_ext;
  logic [3:0]     cycles;

  assign cc         = bal_pkg::cond_e'(iw_q[11:8]);
  assign sdisp      = iw_q[7:0];
  assign short_zero = (sdisp == 8'd0);
  assign cond_ok    = bal_pkg::cond_true(cc, flags_q[3:0]);
  assign cnt_dec    = cnt_q - 16'd1;
  assign disp       = ((op_q == bal_pkg::OP_LOOP) || short_zero)
                      ? {{16{ew_q[15]}}, ew_q} : {{24{sdisp[7]}}, sdisp};
  assign target     = addr_q + 32'd2 + disp;

  always_comb begin
    next_pc     = addr_q + 32'd4;
    taken       = 1'b0;
    count_out   = 16'd0;
    count_write = 1'b0;
    used_ext    = 1'b1;
    cycles      = bal_pkg::CYC_WORD_NT;
    case (op_q)
      bal_pkg::OP_BRANCH: begin
        used_ext = short_zero;
        if (cond_ok) begin
          taken   = 1'b1;
          next_pc = target;
          cycles  = bal_pkg::CYC_TAKEN;
        end else if (!short_zero) begin
          next_pc = addr_q + 32'd2;
          cycles  = bal_pkg::CYC_SHORT_NT;
        end
      end
      bal_pkg::OP_LOOP: begin
        if (!cond_ok) begin
          count_out   = cnt_dec;
          count_write = 1'b1;
          if (cnt_dec == bal_pkg::COUNT_EXPIRED) begin
            cycles = bal_pkg::CYC_EXPIRED;
          end else begin
            taken   = 1'b1;
            next_pc = target;
            cycles  = bal_pkg::CYC_TAKEN;
          end
        end
      end
      default: begin
        taken = 1'b0;
      end
    endcase
  end

  assign out_d = {1'b0, cycles, used_ext, count_write, count_out, taken, next_pc};

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> rtl/bal_checker.sv
`timescale 1ns / 1ps

module bal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic        taken;
  logic        count_write;
  logic        used_ext;
  logic [15:0] count_out;
  logic [3:0]  cycles;

  assign taken       = m_axis_tdata[32];
  assign count_out   = m_axis_tdata[48:33];
  assign count_write = m_axis_tdata[49];
  assign used_ext    = m_axis_tdata[50];
  assign cycles      = m_axis_tdata[54:51];

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed under stall");

  // every taken branch is charged the taken cost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && taken |-> cycles == bal_pkg::CYC_TAKEN)
    else $error("taken branch with wrong cycle charge");

  // a counter write only comes from a loop, which always uses the extension
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && count_write |-> used_ext)
    else $error("counter write without extension word");

  // a loop that falls through with a write has an expired counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && count_write && !taken |->
      count_out == bal_pkg::COUNT_EXPIRED && cycles == bal_pkg::CYC_EXPIRED)
    else $error("loop fell through with live counter");

endmodule

bind branch_and_loop_unit bal_checker u_bal_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
